// ----- rtl/core/wf3_pkg.sv -----
// Shared constants, types and codes of the 3x3 window filter.
`timescale 1ns / 1ps
package wf3_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 12;
    localparam int ROW_W     = HGT_W + 1;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 12;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // 65536 / 9 rounded up; exact floor for sums up to 9 * 255
    localparam logic [12:0] MEAN_RECIP = 13'd7282;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    // filter modes (bit 1 set selects median)
    localparam logic [1:0] MODE_SHARPEN = 2'd0;
    localparam logic [1:0] MODE_MEAN    = 2'd1;
    localparam logic [1:0] MODE_MEDIAN  = 2'd2;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic [1:0]       mode;
    } t_cfg;

    typedef struct packed {
        t_pixel [8:0] win;
        logic         last;
    } t_job;
endpackage

// ----- rtl/core/wf3_if.sv -----
// Stream and configuration channel interfaces of the 3x3 window filter.
`timescale 1ns / 1ps
interface wf3_pix_if;
    import wf3_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel_in;
    logic   is_flush;
    modport source(output valid, pixel_in, is_flush, input ready);
    modport sink(input valid, pixel_in, is_flush, output ready);
endinterface

interface wf3_res_if;
    import wf3_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel_out;
    logic   frame_last;
    modport source(output valid, pixel_out, frame_last, input ready);
    modport sink(input valid, pixel_out, frame_last, output ready);
endinterface

interface wf3_cfg_if;
    import wf3_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/window_filter_3x3.sv -----
// Top level of the streaming 3x3 window filter.
`timescale 1ns / 1ps
// Streaming 3x3 filter on 8-bit grey pixels in raster order, one pixel per
// clock sustained while the queue has room. Borders are edge-replicated; the
// result for image position k leaves with input item k + width + 1, so
// width + 1 flush items drain a frame, and the last result carries
// frame_last. A front end keeps the two line stores (one RAM each, read one
// column ahead) and the window; a four-entry queue feeds a two-stage filter
// pipeline and an output register, and an output stall holds back the input
// only once the queue is full. The user must write registers through the
// configuration channel only while the block is idle; the block does not check.
module window_filter_3x3 (
    input logic    i_clk,
    input logic    i_rst_n,
    wf3_pix_if.sink   i_pix,
    wf3_res_if.source o_res,
    wf3_cfg_if.sink   i_cfg
);
    import wf3_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_room, q_pop, q_avail;
    t_job f_job, q_job;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WID_W'(640);
            r_cfg.height <= HGT_W'(480);
            r_cfg.mode   <= MODE_SHARPEN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDX_WIDTH:  r_cfg.width  <= i_cfg.data[WID_W-1:0];
                CFG_IDX_HEIGHT: r_cfg.height <= i_cfg.data[HGT_W-1:0];
                CFG_IDX_MODE:   r_cfg.mode   <= i_cfg.data[1:0];
                default: begin
                end
            endcase
        end
    end

    wf3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pix.valid),
        .i_pixel (i_pix.pixel_in),
        .i_flush (i_pix.is_flush),
        .o_ready (i_pix.ready),
        .i_room  (q_room),
        .o_push  (q_push),
        .o_job   (f_job)
    );

    wf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_job),
        .o_room  (q_room),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_data  (q_job)
    );

    wf3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_cfg.mode),
        .i_avail (q_avail),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_pixel (o_res.pixel_out),
        .o_last  (o_res.frame_last)
    );
endmodule

// ----- rtl/core/wf3_ram.sv -----
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module wf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/wf3_front.sv -----
// Front end: accepts pixels, keeps line stores, window and raster counters, emits window jobs.
`timescale 1ns / 1ps
module wf3_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wf3_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  wf3_pkg::t_pixel i_pixel,
    input  logic            i_flush,
    output logic            o_ready,
    input  logic            i_room,
    output logic            o_push,
    output wf3_pkg::t_job   o_job
);
    import wf3_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_pixel [8:0]     r_win, n_win;
    logic             r_fwd, n_fwd;
    t_pixel           r_fwd_up, r_fwd_mid;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic             accept, ignore, step, row_end, job_valid;
    t_pixel           ram_up_q, ram_mid_q, rd_up, rd_mid, top, bot;
    t_job             job;

    // effective geometry
    always_comb begin
        w_eff = i_cfg.width;
        if (i_cfg.width == '0) begin
            w_eff = WID_W'(1);
        end else if (i_cfg.width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        h_eff = (i_cfg.height == '0) ? HGT_W'(1) : i_cfg.height;
    end

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign ignore  = i_flush && (r_row < ROW_W'(h_eff));
    assign step    = accept && !ignore;
    assign row_end = r_row >= (ROW_W'(h_eff) + ROW_W'(1));

    // line store reads, with forwarding of a same-address write
    assign rd_up  = r_fwd ? r_fwd_up : ram_up_q;
    assign rd_mid = r_fwd ? r_fwd_mid : ram_mid_q;
    assign top    = (r_row >= ROW_W'(2)) ? rd_up : rd_mid;
    assign bot    = (r_row < ROW_W'(h_eff)) ? i_pixel : rd_mid;

    // window update and job build
    always_comb begin
        n_win     = r_win;
        job.win   = r_win;
        job.last  = 1'b0;
        job_valid = 1'b0;
        if (r_col == '0) begin
            for (int k = 0; k < 3; k++) begin
                job.win[k*3]   = r_win[k*3+1];
                job.win[k*3+1] = r_win[k*3+2];
                job.win[k*3+2] = r_win[k*3+2];
                n_win[k]       = top;
                n_win[3+k]     = rd_mid;
                n_win[6+k]     = bot;
            end
            job_valid = r_row >= ROW_W'(2);
            job.last  = row_end;
        end else begin
            for (int k = 0; k < 3; k++) begin
                n_win[k*3]   = r_win[k*3+1];
                n_win[k*3+1] = r_win[k*3+2];
            end
            n_win[2]  = top;
            n_win[5]  = rd_mid;
            n_win[8]  = bot;
            job.win   = n_win;
            job_valid = r_row >= ROW_W'(1);
        end
    end

    // raster counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (step) begin
            if (r_col == '0 && row_end) begin
                n_col = '0;
                n_row = '0;
            end else if ((WID_W'(r_col) + WID_W'(1)) >= w_eff) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    assign n_fwd = step && (r_col == n_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fwd <= n_fwd;
            if (step) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_up  <= rd_mid;
        r_fwd_mid <= bot;
    end

    wf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_col),
        .i_wdata (rd_mid),
        .i_raddr (n_col),
        .o_rdata (ram_up_q)
    );

    wf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_col),
        .i_wdata (bot),
        .i_raddr (n_col),
        .o_rdata (ram_mid_q)
    );

    assign o_push = step && job_valid;
    assign o_job  = job;
endmodule

// ----- rtl/core/wf3_fifo.sv -----
// Short job queue between the front end and the filter back end.
`timescale 1ns / 1ps
module wf3_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wf3_pkg::t_job i_data,
    output logic          o_room,
    input  logic          i_pop,
    output logic          o_avail,
    output wf3_pkg::t_job o_data
);
    import wf3_pkg::*;

    t_job               r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_room  = r_cnt != Q_CNT_W'(Q_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_room || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("pop from empty queue");
endmodule

// ----- rtl/core/wf3_back.sv -----
// Back end: two-stage filter pipeline (sharpen, mean, median) with output register.
`timescale 1ns / 1ps
module wf3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_mode,
    input  logic            i_avail,
    input  wf3_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output wf3_pkg::t_pixel o_pixel,
    output logic            o_last
);
    import wf3_pkg::*;

    logic               en;
    logic               r_a_valid, r_a_last;
    t_pixel [8:0]       r_a_win;
    logic [8:0][8:0]    r_a_lt, r_a_le;
    logic [SUM_W-1:0]   r_a_sum, sum;
    logic               r_out_valid, r_out_last;
    t_pixel             r_out_pixel, result, med;
    logic [3:0]         cnt_lt, cnt_le;
    logic [24:0]        mean_prod;
    logic [11:0]        cen10;
    logic signed [13:0] sharp;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_avail;

    // stage A: pairwise compares and sum
    always_comb begin
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            sum = sum + SUM_W'(i_job.win[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_win  <= i_job.win;
            r_a_last <= i_job.last;
            r_a_sum  <= sum;
            for (int i = 0; i < 9; i++) begin
                for (int j = 0; j < 9; j++) begin
                    r_a_lt[i][j] <= i_job.win[j] < i_job.win[i];
                    r_a_le[i][j] <= i_job.win[j] <= i_job.win[i];
                end
            end
        end
    end

    // stage B: median pick by rank, mean by reciprocal, clamped sharpen
    always_comb begin
        med = r_a_win[0];
        for (int i = 8; i >= 0; i--) begin
            cnt_lt = 4'($countones(r_a_lt[i]));
            cnt_le = 4'($countones(r_a_le[i]));
            if (cnt_lt <= 4'd4 && cnt_le >= 4'd5) begin
                med = r_a_win[i];
            end
        end
    end

    assign mean_prod = 25'(r_a_sum) * 25'(MEAN_RECIP);
    assign cen10     = 12'(r_a_win[4]) * 12'd10;
    assign sharp     = $signed({2'b00, cen10}) - $signed({2'b00, r_a_sum});

    always_comb begin
        if (i_mode[1]) begin
            result = med;
        end else if (i_mode == MODE_MEAN) begin
            result = mean_prod[23:16];
        end else if (sharp < 14'sd0) begin
            result = '0;
        end else if (sharp > 14'sd255) begin
            result = 8'd255;
        end else begin
            result = sharp[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_avail;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pixel <= result;
            r_out_last  <= r_a_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_last  = r_out_last;
endmodule
